// ===== rtl/core/length_prefixed_request_parser_defines.svh =====
// Assertion macros used by the request parser top level.
`ifndef LENGTH_PREFIXED_REQUEST_PARSER_DEFINES_SVH
`define LENGTH_PREFIXED_REQUEST_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every clock once reset is released.
`define LPRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock once reset is released.
`define LPRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lprp_pkg.sv =====
// Shared types and constants of the length-prefixed request parser.
package lprp_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned INDEX_W    = 20;
    localparam int unsigned COUNT_W    = 21;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned STATUS_W   = 3;

    localparam logic [COUNT_W-1:0] ARG_LIMIT_RESET = 21'd1024;

    localparam logic [STATUS_W-1:0] ST_RUN       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRAILING  = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0]   payload_byte;
        logic                payload_valid;
        logic [INDEX_W-1:0]  arg_index;
        logic                arg_done;
        logic                frame_done;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

// ===== rtl/core/lprp_parser.sv =====
// Frame parsing state and the per-byte result computation.
module lprp_parser (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [lprp_pkg::COUNT_W-1:0]        arg_limit,
    input  logic                                in_fire,
    input  logic [lprp_pkg::BYTE_W-1:0]         data_byte,
    input  logic                                frame_last,
    output lprp_pkg::result_t                   result
);

    typedef enum logic [1:0] {
        PH_COUNT,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_DONE
    } phase_t;

    phase_t                          phase_reg,    phase_next;
    logic [1:0]                      pos_reg,      pos_next;
    logic [23:0]                     shift_reg,    shift_next;
    logic [lprp_pkg::COUNT_W-1:0]    expected_reg, expected_next;
    logic [lprp_pkg::COUNT_W-1:0]    done_reg,     done_next;
    logic [lprp_pkg::WORD_W-1:0]     remain_reg,   remain_next;
    logic [lprp_pkg::STATUS_W-1:0]   err_reg,      err_next;

    logic                            word_complete;
    logic [lprp_pkg::WORD_W-1:0]     word;
    logic [23:0]                     shift_acc;
    logic [lprp_pkg::COUNT_W-1:0]    done_inc;
    logic [lprp_pkg::WORD_W-1:0]     remain_dec;

    assign word_complete = (pos_reg == 2'd3);
    assign word          = {data_byte, shift_reg};
    assign done_inc      = done_reg + 21'd1;
    assign remain_dec    = remain_reg - 32'd1;

    // Little-endian assembly of the first three bytes of a word.
    always_comb
    begin
        shift_acc = shift_reg;
        case (pos_reg)
            2'd0:    shift_acc[7:0]   = data_byte;
            2'd1:    shift_acc[15:8]  = data_byte;
            2'd2:    shift_acc[23:16] = data_byte;
            default: shift_acc        = shift_reg;
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        shift_next    = shift_reg;
        expected_next = expected_reg;
        done_next     = done_reg;
        remain_next   = remain_reg;
        err_next      = err_reg;

        result.payload_byte  = '0;
        result.payload_valid = 1'b0;
        result.arg_index     = done_reg[lprp_pkg::INDEX_W-1:0];
        result.arg_done      = 1'b0;
        result.frame_done    = frame_last;
        result.status        = lprp_pkg::ST_RUN;

        if (err_reg == lprp_pkg::ST_RUN)
        begin
            unique case (phase_reg)
                PH_COUNT:
                begin
                    pos_next   = pos_reg + 2'd1;
                    shift_next = word_complete ? 24'd0 : shift_acc;
                    if (word_complete)
                    begin
                        if (word > {11'd0, arg_limit})
                        begin
                            err_next = lprp_pkg::ST_TOO_MANY;
                        end
                        else
                        begin
                            expected_next = word[lprp_pkg::COUNT_W-1:0];
                            phase_next    = (word == '0) ? PH_DONE : PH_LENGTH;
                        end
                    end
                end
                PH_LENGTH:
                begin
                    pos_next   = pos_reg + 2'd1;
                    shift_next = word_complete ? 24'd0 : shift_acc;
                    if (word_complete)
                    begin
                        if (word == '0)
                        begin
                            result.arg_done = 1'b1;
                            done_next       = done_inc;
                            phase_next      = (done_inc == expected_reg) ? PH_DONE : PH_LENGTH;
                        end
                        else
                        begin
                            remain_next = word;
                            phase_next  = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    result.payload_byte  = data_byte;
                    result.payload_valid = 1'b1;
                    remain_next          = remain_dec;
                    if (remain_dec == '0)
                    begin
                        result.arg_done = 1'b1;
                        done_next       = done_inc;
                        phase_next      = (done_inc == expected_reg) ? PH_DONE : PH_LENGTH;
                    end
                end
                PH_DONE:
                begin
                    err_next = lprp_pkg::ST_TRAILING;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        // The last byte reports the frame and returns the parser to its idle state.
        if (frame_last)
        begin
            if (err_next != lprp_pkg::ST_RUN)
                result.status = err_next;
            else if (phase_next == PH_DONE)
                result.status = lprp_pkg::ST_ACCEPTED;
            else
                result.status = lprp_pkg::ST_TRUNCATED;

            phase_next    = PH_COUNT;
            pos_next      = 2'd0;
            shift_next    = '0;
            expected_next = '0;
            done_next     = '0;
            remain_next   = '0;
            err_next      = lprp_pkg::ST_RUN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_COUNT;
            pos_reg      <= 2'd0;
            shift_reg    <= '0;
            expected_reg <= '0;
            done_reg     <= '0;
            remain_reg   <= '0;
            err_reg      <= lprp_pkg::ST_RUN;
        end
        else if (in_fire)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            shift_reg    <= shift_next;
            expected_reg <= expected_next;
            done_reg     <= done_next;
            remain_reg   <= remain_next;
            err_reg      <= err_next;
        end
    end

endmodule

// ===== rtl/core/length_prefixed_request_parser.sv =====
// Top level of the length-prefixed request parser with its output buffering.
//
// The parser takes one request body byte per clock cycle while in_stall is low and
// returns exactly one result per byte, registered into the output register when
// that is free. A body is a 32-bit little-endian argument count followed, for each
// argument, by a 32-bit little-endian length and that many payload bytes;
// frame_last flags the last byte of the body, and the result for that byte
// carries the status (accepted, truncated, too many arguments, trailing bytes).
// The first error holds until the frame ends. The whole per-byte update is one
// pass of logic from the parser state into a result register, so a new byte is
// accepted every cycle as long as results are taken. Results sit in a two-entry
// buffer (output register plus skid register), and in_stall is the skid
// register's valid bit: a byte accepted while the output register is stalled
// parks its result in the skid register, and the input then waits until that
// result has moved up, so even a one-cycle out_stall that catches a byte stalls
// the input. The argument limit is written through cfg_wr_en / cfg_wr_data
// and should only be changed between requests.
`include "length_prefixed_request_parser_defines.svh"

module length_prefixed_request_parser (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_wr_en,
    input  logic [lprp_pkg::COUNT_W-1:0]         cfg_wr_data,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [lprp_pkg::BYTE_W-1:0]          data_byte,
    input  logic                                 frame_last,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [lprp_pkg::BYTE_W-1:0]          payload_byte,
    output logic                                 payload_valid,
    output logic [lprp_pkg::INDEX_W-1:0]         arg_index,
    output logic                                 arg_done,
    output logic                                 frame_done,
    output logic [lprp_pkg::STATUS_W-1:0]        status
);

    logic [lprp_pkg::COUNT_W-1:0] arg_limit_reg;

    logic                in_fire;
    logic                out_take;
    lprp_pkg::result_t   step_result;

    logic                out_valid_reg,  out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    lprp_pkg::result_t   out_data_reg,   out_data_next;
    lprp_pkg::result_t   skid_data_reg,  skid_data_next;

    // The skid register is the only thing that can block the input side.
    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            arg_limit_reg <= lprp_pkg::ARG_LIMIT_RESET;
        else if (cfg_wr_en)
            arg_limit_reg <= cfg_wr_data;
    end

    lprp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .arg_limit  (arg_limit_reg),
        .in_fire    (in_fire),
        .data_byte  (data_byte),
        .frame_last (frame_last),
        .result     (step_result)
    );

    // When the output register frees up it refills from the skid register first,
    // so results leave in the order their bytes arrived.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (in_fire)
            begin
                out_valid_next = 1'b1;
                out_data_next  = step_result;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = step_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid     = out_valid_reg;
    assign payload_byte  = out_data_reg.payload_byte;
    assign payload_valid = out_data_reg.payload_valid;
    assign arg_index     = out_data_reg.arg_index;
    assign arg_done      = out_data_reg.arg_done;
    assign frame_done    = out_data_reg.frame_done;
    assign status        = out_data_reg.status;

    `LPRP_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid holds a result while output register is empty")
    `LPRP_ASSERT_NOW(a_status_only_at_end, out_valid_reg && !out_data_reg.frame_done,
        out_data_reg.status == lprp_pkg::ST_RUN, "status reported before frame end")
    `LPRP_ASSERT_NEXT(a_stalled_fire_to_skid, in_fire && out_valid_reg && out_stall,
        skid_valid_reg, "result accepted under stall was not buffered")
    `LPRP_ASSERT_NOW(a_payload_has_no_error, out_valid_reg && out_data_reg.payload_valid,
        out_data_reg.status != lprp_pkg::ST_TOO_MANY
            && out_data_reg.status != lprp_pkg::ST_TRAILING,
        "payload byte reported with an error status")

endmodule

// ===== test/length_prefixed_request_parser_test.sv =====
// Self-checking testbench for the length-prefixed request parser.
module length_prefixed_request_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Where the body decoder stands within the current request.
    typedef enum logic [1:0] {
        COUNT_FIELD,
        LENGTH_FIELD,
        PAYLOAD_BYTES,
        BODY_COMPLETE
    } parse_phase_t;

    // One byte of a request body as the sender presents it.
    typedef struct packed {
        logic [lprp_pkg::BYTE_W-1:0] data;
        logic                        last;
    } body_byte_t;

    typedef logic [lprp_pkg::BYTE_W-1:0] byte_list_t[$];

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [lprp_pkg::COUNT_W-1:0]  cfg_wr_data = '0;
    logic                          in_valid    = 1'b0;
    logic                          in_stall;
    logic [lprp_pkg::BYTE_W-1:0]   data_byte   = '0;
    logic                          frame_last  = 1'b0;
    logic                          out_valid;
    logic                          out_stall   = 1'b0;
    logic [lprp_pkg::BYTE_W-1:0]   payload_byte;
    logic                          payload_valid;
    logic [lprp_pkg::INDEX_W-1:0]  arg_index;
    logic                          arg_done;
    logic                          frame_done;
    logic [lprp_pkg::STATUS_W-1:0] status;

    length_prefixed_request_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .frame_last   (frame_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .payload_byte (payload_byte),
        .payload_valid(payload_valid),
        .arg_index    (arg_index),
        .arg_done     (arg_done),
        .frame_done   (frame_done),
        .status       (status)
    );

    always #2 clk = ~clk;

    // Bytes waiting to be offered to the parser, and the results that the
    // accepted bytes must produce, oldest first.
    body_byte_t          bytes_to_send[$];
    lprp_pkg::result_t   awaited_results[$];

    // Our own copy of the parser state, updated once per accepted byte.
    parse_phase_t                  decode_phase = COUNT_FIELD;
    logic [1:0]                    word_pos     = '0;
    logic [lprp_pkg::WORD_W-1:0]   word_acc     = '0;
    logic [lprp_pkg::COUNT_W-1:0]  args_total   = '0;
    logic [lprp_pkg::COUNT_W-1:0]  args_seen    = '0;
    logic [lprp_pkg::WORD_W-1:0]   bytes_left   = '0;
    logic [lprp_pkg::STATUS_W-1:0] first_error  = lprp_pkg::ST_RUN;
    logic [lprp_pkg::COUNT_W-1:0]  limit_args   = lprp_pkg::ARG_LIMIT_RESET;

    int  fault_count     = 0;
    int  results_checked = 0;
    int  bytes_accepted  = 0;
    int  frames_queued   = 0;
    int  frames_by_status[5];
    bit  calm            = 1'b0;
    logic idling_on      = 1'b0;
    int  stretch_left    = 0;

    // Every request starts from the same empty state; only the limit survives.
    function automatic void clear_request();
        decode_phase = COUNT_FIELD;
        word_pos     = '0;
        word_acc     = '0;
        args_total   = '0;
        args_seen    = '0;
        bytes_left   = '0;
        first_error  = lprp_pkg::ST_RUN;
    endfunction

    // One more argument is complete; either the body is complete or the next
    // length field follows.
    function automatic void close_argument();
        args_seen    = args_seen + 1'b1;
        decode_phase = (args_seen == args_total) ? BODY_COMPLETE : LENGTH_FIELD;
    endfunction

    // Computes the result for one body byte and advances the state.
    function automatic lprp_pkg::result_t parse_byte(input logic [lprp_pkg::BYTE_W-1:0] b,
                                                     input logic last);
        lprp_pkg::result_t           r;
        logic [lprp_pkg::WORD_W-1:0] w;
        logic                        word_full;
        r           = '0;
        r.arg_index = args_seen[lprp_pkg::INDEX_W-1:0];
        if (first_error == lprp_pkg::ST_RUN)
        begin
            case (decode_phase)
                COUNT_FIELD, LENGTH_FIELD:
                begin
                    // Both prefix words are little-endian: byte k lands at bits 8k.
                    w         = word_acc | (lprp_pkg::WORD_W'(b) << (8 * word_pos));
                    word_full = (word_pos == 2'd3);
                    word_pos  = word_pos + 1'b1;
                    word_acc  = word_full ? '0 : w;
                    if (word_full && decode_phase == COUNT_FIELD)
                    begin
                        if (w > lprp_pkg::WORD_W'(limit_args))
                        begin
                            first_error = lprp_pkg::ST_TOO_MANY;
                        end
                        else
                        begin
                            args_total   = w[lprp_pkg::COUNT_W-1:0];
                            decode_phase = (w == 0) ? BODY_COMPLETE : LENGTH_FIELD;
                        end
                    end
                    else if (word_full)
                    begin
                        // A zero length closes its argument on the length's last byte.
                        if (w == 0)
                        begin
                            r.arg_done = 1'b1;
                            close_argument();
                        end
                        else
                        begin
                            bytes_left   = w;
                            decode_phase = PAYLOAD_BYTES;
                        end
                    end
                end
                PAYLOAD_BYTES:
                begin
                    r.payload_byte  = b;
                    r.payload_valid = 1'b1;
                    bytes_left      = bytes_left - 1'b1;
                    if (bytes_left == 0)
                    begin
                        r.arg_done = 1'b1;
                        close_argument();
                    end
                end
                default:
                begin
                    first_error = lprp_pkg::ST_TRAILING;
                end
            endcase
        end
        if (last)
        begin
            r.frame_done = 1'b1;
            if (first_error != lprp_pkg::ST_RUN)
                r.status = first_error;
            else if (decode_phase == BODY_COMPLETE)
                r.status = lprp_pkg::ST_ACCEPTED;
            else
                r.status = lprp_pkg::ST_TRUNCATED;
            clear_request();
        end
        return r;
    endfunction

    function automatic void put_word(ref byte_list_t q,
                                     input logic [lprp_pkg::WORD_W-1:0] w);
        for (int k = 0; k < 4; k++)
            q.insert(q.size(), w[8*k +: 8]);
    endfunction

    // Builds a well-formed body under the current limit. With huge_len the
    // last argument claims a length far beyond what is ever sent, so the
    // caller has to cut the body anyway.
    function automatic void build_body(ref byte_list_t q, input bit huge_len);
        int unsigned n;
        int unsigned len;
        n = $urandom_range(0, (limit_args < 4) ? limit_args : 4);
        put_word(q, n);
        for (int unsigned i = 0; i < n; i++)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
            if (huge_len && i == n - 1)
            begin
                put_word(q, $urandom | 32'h100);
                len = $urandom_range(0, 5);
            end
            else
            begin
                put_word(q, len);
            end
            for (int unsigned j = 0; j < len; j++)
                q.insert(q.size(), lprp_pkg::BYTE_W'($urandom));
        end
    endfunction

    function automatic void queue_frame(input byte_list_t q);
        foreach (q[i])
            bytes_to_send.insert(bytes_to_send.size(),
                                 body_byte_t'{data: q[i], last: (i == q.size() - 1)});
        frames_queued++;
    endfunction

    // Half are well-formed bodies with random content; the rest are cut short,
    // padded with trailing bytes, over the argument limit, or plain noise.
    task automatic load_random_frames(input int budget);
        byte_list_t                  frame;
        int                          queued;
        int unsigned                 pick;
        logic [lprp_pkg::WORD_W-1:0] n;
        queued = 0;
        while (queued < budget)
        begin
            frame = {};
            pick  = $urandom_range(0, 19);
            if (pick < 10)
            begin
                build_body(frame, 1'b0);
            end
            else if (pick < 13)
            begin
                build_body(frame, $urandom_range(0, 1));
                if (frame.size() > 1)
                    frame = frame[0:$urandom_range(0, frame.size() - 2)];
            end
            else if (pick < 15)
            begin
                build_body(frame, 1'b0);
                repeat ($urandom_range(1, 3))
                    frame.insert(frame.size(), lprp_pkg::BYTE_W'($urandom));
            end
            else if (pick < 17)
            begin
                // The bytes after the count must be ignored until the frame ends.
                if ($urandom_range(0, 1))
                    n = lprp_pkg::WORD_W'(limit_args) + 1 + $urandom_range(0, 2);
                else
                    n = $urandom | 32'h8000_0000;
                put_word(frame, n);
                repeat ($urandom_range(0, 6))
                    frame.insert(frame.size(), lprp_pkg::BYTE_W'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 12))
                    frame.insert(frame.size(), lprp_pkg::BYTE_W'($urandom));
            end
            queue_frame(frame);
            queued += frame.size();
        end
    endtask

    // Waits until every queued byte has gone in and every result has come out.
    task automatic wait_for_drain();
        while (bytes_to_send.size() != 0 || in_valid || awaited_results.size() != 0)
            @(negedge clk);
    endtask

    // The limit only changes while the parser is idle, between requests.
    task automatic write_limit(input logic [lprp_pkg::COUNT_W-1:0] v);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        limit_args   = v;
        @(posedge clk);
    endtask

    task automatic note_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want)
        begin
            fault_count++;
            if (fault_count <= 10)
                $display("mismatch on %s at %0t: expected 0x%0h, got 0x%0h",
                         name, $realtime, want, got);
        end
    endtask

    // Idling comes in stretches: for a while both sides may pause, then for a
    // while neither does. Near the end of the run there is no idling at all.
    always @(posedge clk)
    begin
        if (stretch_left == 0)
        begin
            idling_on    <= !calm && ($urandom_range(0, 3) != 0);
            stretch_left  = $urandom_range(20, 120);
        end
        else
        begin
            stretch_left--;
        end
    end

    // Request driver. The prediction is made at the edge where the parser takes
    // the byte, so the expected result is queued in acceptance order.
    always @(posedge clk)
    begin
        int         send_gap;
        body_byte_t next_byte;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                awaited_results.insert(awaited_results.size(),
                                       parse_byte(data_byte, frame_last));
                bytes_accepted++;
            end
            // A new byte may only be presented once the current one is taken.
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap--;
                end
                else if (bytes_to_send.size() != 0)
                begin
                    next_byte   = bytes_to_send.pop_front();
                    in_valid   <= 1'b1;
                    data_byte  <= next_byte.data;
                    frame_last <= next_byte.last;
                    if (idling_on && !calm && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 4);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall generator.
    always @(posedge clk)
    begin
        lprp_pkg::result_t want;
        int                hold_left;
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (awaited_results.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result at %0t: status %0d", $realtime, status);
            end
            else
            begin
                want = awaited_results.pop_front();
                note_field("payload_byte", want.payload_byte, payload_byte);
                note_field("payload_valid", want.payload_valid, payload_valid);
                note_field("arg_index", want.arg_index, arg_index);
                note_field("arg_done", want.arg_done, arg_done);
                note_field("frame_done", want.frame_done, frame_done);
                note_field("status", want.status, status);
                if (frame_done === 1'b1 && status <= lprp_pkg::ST_TRAILING)
                    frames_by_status[status]++;
            end
        end
        if (!idling_on || calm)
        begin
            out_stall <= 1'b0;
            hold_left  = 0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            hold_left  = $urandom_range(0, 3);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        byte_list_t                   frame;
        logic [lprp_pkg::COUNT_W-1:0] limits[6];
        limits = '{21'd0, 21'd1, 21'd1048576, 21'h1F_FFFF, 21'd3, 21'd0};
        limits[5] = lprp_pkg::COUNT_W'($urandom_range(2, 40));
        clear_request();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed bodies under the reset limit.
        // A count of zero is a complete body on its own.
        frame = {};
        put_word(frame, 32'd0);
        queue_frame(frame);
        // One zero-length argument, closed on the last byte of its length.
        frame = {};
        put_word(frame, 32'd1);
        put_word(frame, 32'd0);
        queue_frame(frame);
        // Count above the limit, raised by the frame's last byte itself.
        frame = {};
        put_word(frame, 32'hFFFF_FFFF);
        queue_frame(frame);
        // A trailing byte that is also the frame's last byte.
        frame = {};
        put_word(frame, 32'd0);
        frame.insert(frame.size(), 8'hAA);
        queue_frame(frame);
        // Body that ends in the middle of the count.
        frame = '{8'h01, 8'h00, 8'h00};
        queue_frame(frame);
        // The sender holds off here until every result is back.
        wait_for_drain();

        // Random bodies under a series of limits, the extremes among them.
        foreach (limits[i])
        begin
            write_limit(limits[i]);
            if (i == 5)
                calm = 1'b1;
            load_random_frames(240);
            wait_for_drain();
        end
        repeat (8) @(posedge clk);

        $display("%0d body bytes from %0d requests over six argument limits, %0d results",
                 bytes_accepted, frames_queued, results_checked);
        $display("status seen: %0d accepted, %0d truncated, %0d over limit, %0d trailing",
                 frames_by_status[lprp_pkg::ST_ACCEPTED],
                 frames_by_status[lprp_pkg::ST_TRUNCATED],
                 frames_by_status[lprp_pkg::ST_TOO_MANY],
                 frames_by_status[lprp_pkg::ST_TRAILING]);
        if (fault_count == 0 && awaited_results.size() == 0)
            $display("length_prefixed_request_parser_test OK");
        else
            $display("length_prefixed_request_parser_test NOT OK");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("length_prefixed_request_parser_test NOT OK");
        $finish;
    end

endmodule
